>>> src/assert_macros.svh
// Assertion shorthands, clocked on clk with arst_n low as the disable.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define TSA_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tsa assertion failed");

// Next-cycle implication.
`define TSA_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tsa assertion failed");

`endif

>>> src/tsa_pkg.sv
package tsa_pkg;
	localparam int SLOTS  = 64;
	localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W  = $clog2(SLOTS + 1);
	localparam int SLOT_W = 6;
	localparam int HEAP_W = 16;
	localparam int TEX_W  = 8;
	localparam int CNTP_W = 7;

	localparam logic [1:0] FN_ALLOC   = 2'd0;
	localparam logic [1:0] FN_RELEASE = 2'd1;
	localparam logic [1:0] FN_SCAN    = 2'd2;

	typedef enum logic [1:0] {
		STS_OK,
		STS_FULL,
		STS_UNUSED,
		STS_EMPTY
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ALLOC,
		S_ALLOC_WR,
		S_REL,
		S_REL_OUT,
		S_SCAN,
		S_SCAN_DRAIN,
		S_SCAN_DONE
	} state_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		logic [IDX_W-1:0] data;
	} stk_wr_t;

	typedef struct packed {
		logic              en;
		logic [IDX_W-1:0]  addr;
		logic [HEAP_W-1:0] heap;
		logic [TEX_W-1:0]  tx;
		logic [TEX_W-1:0]  ty;
	} tbl_wr_t;
endpackage

>>> src/tsa_free_stack.sv
// Free-slot stack storage. Entries never written read back as their own index.
module tsa_free_stack import tsa_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  stk_wr_t          wr,
	input  logic [IDX_W-1:0] raddr,
	output logic [IDX_W-1:0] rdata
);
	logic [IDX_W-1:0] mem [SLOTS];
	logic [IDX_W-1:0] rd_q;
	logic [IDX_W-1:0] raddr_q;
	logic [SLOTS-1:0] written_q;
	logic             hit_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rd_q    <= mem[raddr];
		raddr_q <= raddr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			hit_q     <= 1'b0;
		end else begin
			if (wr.en) begin
				written_q[wr.addr] <= 1'b1;
			end
			hit_q <= written_q[raddr];
		end
	end

	assign rdata = hit_q ? rd_q : raddr_q;
endmodule

>>> src/tsa_slot_table.sv
// Slot mapping table: heap tile and texture coordinate, registered read.
module tsa_slot_table import tsa_pkg::*; (
	input  logic              clk,
	input  tbl_wr_t           wr,
	input  logic [IDX_W-1:0]  raddr,
	output logic [HEAP_W-1:0] rd_heap,
	output logic [TEX_W-1:0]  rd_tx,
	output logic [TEX_W-1:0]  rd_ty
);
	localparam int ENT_W = HEAP_W + 2 * TEX_W;

	logic [ENT_W-1:0] mem [SLOTS];
	logic [ENT_W-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= {wr.heap, wr.ty, wr.tx};
		end
		rd_q <= mem[raddr];
	end

	assign rd_heap = rd_q[ENT_W-1 -: HEAP_W];
	assign rd_ty   = rd_q[2*TEX_W-1 -: TEX_W];
	assign rd_tx   = rd_q[TEX_W-1:0];
endmodule

>>> src/tile_slot_allocator.sv
// Tile slot allocator. A command is taken when start is high and busy is low;
// busy then stays high until the command is finished. Each result shows on
// the result ports for exactly one cycle with done high; there is no way to
// hold results off, so the receiver must take every done cycle. Allocate
// walks S_ALLOC and S_ALLOC_WR, release S_REL and S_REL_OUT; both give their
// result in the first cycle busy is low again (allocate with no free slot
// ends in S_ALLOC). Scan walks S_SCAN, S_SCAN_DRAIN and S_SCAN_DONE: a
// counter steps the read port of the slot table through every slot, one slot
// a cycle. A found mapping waits in a holding register until the next one is
// found or the walk ends, so its result trails the counter through the pipe,
// holding and output registers, and the final result shows in the first
// cycle busy is low. Every used slot gives one result, the last one with last
// high, or one result with status "empty" if nothing is mapped. The free
// stack and slot table each have one read port. Reset needs no clearing pass.
module tile_slot_allocator import tsa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        func,
	input  logic [HEAP_W-1:0] heap_tile,
	input  logic [TEX_W-1:0]  tex_x,
	input  logic [TEX_W-1:0]  tex_y,
	input  logic [SLOT_W-1:0] slot,
	output logic              done,
	output logic [1:0]        status,
	output logic [SLOT_W-1:0] slot_out,
	output logic [HEAP_W-1:0] heap_tile_out,
	output logic [TEX_W-1:0]  tex_x_out,
	output logic [TEX_W-1:0]  tex_y_out,
	output logic [CNTP_W-1:0] free_count,
	output logic              last
);
	state_t state_q, state_d;
	logic   accept;

	// command capture
	logic [HEAP_W-1:0] heap_q;
	logic [TEX_W-1:0]  tx_q, ty_q;
	logic [SLOT_W-1:0] slot_in_q;

	// allocator state: stack pointer doubles as the free count
	logic [CNT_W-1:0] free_top_q;
	logic [CNT_W-1:0] top_m1;
	logic [SLOTS-1:0] used_q;
	logic             rel_ok, rel_ok_q;

	// scan walker and its one-stage pipe
	logic [IDX_W-1:0] idx_q;
	logic             scan_v_s1, hit_s1;
	logic [IDX_W-1:0] slot_s1;

	// a found mapping waits here until we know whether another follows
	logic              pend_q;
	logic [IDX_W-1:0]  pend_slot_q;
	logic [HEAP_W-1:0] pend_heap_q;
	logic [TEX_W-1:0]  pend_tx_q, pend_ty_q;

	// storage ports
	stk_wr_t           stk_wr;
	tbl_wr_t           tbl_wr;
	logic [IDX_W-1:0]  stk_raddr, stk_rdata, tbl_raddr;
	logic [HEAP_W-1:0] rd_heap;
	logic [TEX_W-1:0]  rd_tx, rd_ty;

	// sequencer controls
	logic              top_dec, top_inc, used_set, used_clr, pend_load;
	logic              emit, e_last;
	status_t           e_status;
	logic [SLOT_W-1:0] e_slot;
	logic [HEAP_W-1:0] e_heap;
	logic [TEX_W-1:0]  e_tx, e_ty;

	// output registers
	logic              done_q, last_q;
	status_t           status_q;
	logic [SLOT_W-1:0] slot_out_q;
	logic [HEAP_W-1:0] heap_out_q;
	logic [TEX_W-1:0]  tx_out_q, ty_out_q;
	logic [CNT_W-1:0]  cnt_out_q;

	tsa_free_stack u_stack (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (stk_wr),
		.raddr  (stk_raddr),
		.rdata  (stk_rdata)
	);

	tsa_slot_table u_table (
		.clk     (clk),
		.wr      (tbl_wr),
		.raddr   (tbl_raddr),
		.rd_heap (rd_heap),
		.rd_tx   (rd_tx),
		.rd_ty   (rd_ty)
	);

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign top_m1 = free_top_q - 1'b1;

	// a release needs an in-range, used slot and room on the stack
	assign rel_ok = (int'(slot_in_q) < SLOTS) && used_q[slot_in_q[IDX_W-1:0]] &&
		(free_top_q < CNT_W'(SLOTS));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (func)
						FN_ALLOC:   state_d = S_ALLOC;
						FN_RELEASE: state_d = S_REL;
						FN_SCAN:    state_d = S_SCAN;
						default:    state_d = S_IDLE;
					endcase
				end
			end
			S_ALLOC:      state_d = (free_top_q == '0) ? S_IDLE : S_ALLOC_WR;
			S_ALLOC_WR:   state_d = S_IDLE;
			S_REL:        state_d = S_REL_OUT;
			S_REL_OUT:    state_d = S_IDLE;
			S_SCAN:       state_d = (idx_q == IDX_W'(SLOTS - 1)) ? S_SCAN_DRAIN : S_SCAN;
			S_SCAN_DRAIN: state_d = S_SCAN_DONE;
			S_SCAN_DONE:  state_d = S_IDLE;
			default:      state_d = S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		stk_wr    = '0;
		tbl_wr    = '0;
		stk_raddr = top_m1[IDX_W-1:0];
		tbl_raddr = slot_in_q[IDX_W-1:0];
		top_dec   = 1'b0;
		top_inc   = 1'b0;
		used_set  = 1'b0;
		used_clr  = 1'b0;
		pend_load = scan_v_s1 && hit_s1;
		emit      = 1'b0;
		e_status  = STS_OK;
		e_slot    = '0;
		e_heap    = '0;
		e_tx      = '0;
		e_ty      = '0;
		e_last    = 1'b1;

		// a new hit pushes the waiting one out; more follow, so not last
		if (pend_load && pend_q) begin
			emit   = 1'b1;
			e_slot = SLOT_W'(pend_slot_q);
			e_heap = pend_heap_q;
			e_tx   = pend_tx_q;
			e_ty   = pend_ty_q;
			e_last = 1'b0;
		end

		unique case (state_q)
			S_ALLOC: begin
				if (free_top_q == '0) begin
					emit     = 1'b1;
					e_status = STS_FULL;
				end else begin
					top_dec = 1'b1;
				end
			end
			S_ALLOC_WR: begin
				tbl_wr.en   = 1'b1;
				tbl_wr.addr = stk_rdata;
				tbl_wr.heap = heap_q;
				tbl_wr.tx   = tx_q;
				tbl_wr.ty   = ty_q;
				used_set    = 1'b1;
				emit        = 1'b1;
				e_slot      = SLOT_W'(stk_rdata);
				e_heap      = heap_q;
				e_tx        = tx_q;
				e_ty        = ty_q;
			end
			S_REL: begin
				if (rel_ok) begin
					stk_wr.en   = 1'b1;
					stk_wr.addr = free_top_q[IDX_W-1:0];
					stk_wr.data = slot_in_q[IDX_W-1:0];
					top_inc     = 1'b1;
					used_clr    = 1'b1;
				end
			end
			S_REL_OUT: begin
				emit   = 1'b1;
				e_slot = slot_in_q;
				if (rel_ok_q) begin
					e_heap = rd_heap;
					e_tx   = rd_tx;
					e_ty   = rd_ty;
				end else begin
					e_status = STS_UNUSED;
				end
			end
			S_SCAN: begin
				tbl_raddr = idx_q;
			end
			S_SCAN_DONE: begin
				emit = 1'b1;
				if (pend_q) begin
					e_slot = SLOT_W'(pend_slot_q);
					e_heap = pend_heap_q;
					e_tx   = pend_tx_q;
					e_ty   = pend_ty_q;
				end else begin
					e_status = STS_EMPTY;
				end
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			free_top_q <= CNT_W'(SLOTS);
			used_q     <= '0;
			rel_ok_q   <= 1'b0;
			idx_q      <= '0;
			scan_v_s1  <= 1'b0;
			hit_s1     <= 1'b0;
			pend_q     <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (top_dec) begin
				free_top_q <= top_m1;
			end else if (top_inc) begin
				free_top_q <= free_top_q + 1'b1;
			end
			if (used_set) begin
				used_q[stk_rdata] <= 1'b1;
			end
			if (used_clr) begin
				used_q[slot_in_q[IDX_W-1:0]] <= 1'b0;
			end
			if (state_q == S_REL) begin
				rel_ok_q <= rel_ok;
			end
			if (accept) begin
				idx_q <= '0;
			end else if (state_q == S_SCAN) begin
				idx_q <= idx_q + 1'b1;
			end
			scan_v_s1 <= (state_q == S_SCAN);
			hit_s1    <= used_q[idx_q];
			if (accept) begin
				pend_q <= 1'b0;
			end else if (pend_load) begin
				pend_q <= 1'b1;
			end
			done_q <= emit;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			heap_q    <= heap_tile;
			tx_q      <= tex_x;
			ty_q      <= tex_y;
			slot_in_q <= slot;
		end
		slot_s1 <= idx_q;
		if (pend_load) begin
			pend_slot_q <= slot_s1;
			pend_heap_q <= rd_heap;
			pend_tx_q   <= rd_tx;
			pend_ty_q   <= rd_ty;
		end
		if (emit) begin
			status_q   <= e_status;
			slot_out_q <= e_slot;
			heap_out_q <= e_heap;
			tx_out_q   <= e_tx;
			ty_out_q   <= e_ty;
			last_q     <= e_last;
			cnt_out_q  <= (top_dec ? top_m1 : (top_inc ? free_top_q + 1'b1 : free_top_q));
		end
	end

	assign done          = done_q;
	assign status        = status_q;
	assign slot_out      = slot_out_q;
	assign heap_tile_out = heap_out_q;
	assign tex_x_out     = tx_out_q;
	assign tex_y_out     = ty_out_q;
	assign free_count    = CNTP_W'(cnt_out_q);
	assign last          = last_q;
endmodule

>>> src/tsa_checker.sv
`include "assert_macros.svh"

module tsa_checker import tsa_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic [1:0]        func,
	input logic              done,
	input logic [1:0]        status,
	input logic [CNTP_W-1:0] free_count,
	input logic              last
);
	`TSA_ASSERT_IMP(a_cnt_range, done, free_count <= CNTP_W'(SLOTS))
	`TSA_ASSERT_IMP(a_full_zero, done && status == STS_FULL, free_count == '0)
	`TSA_ASSERT_IMP(a_err_last, done && status != STS_OK, last)
	`TSA_ASSERT_NXT(a_last_gap, done && last, !done)
	`TSA_ASSERT_NXT(a_busy_after, start && !busy && (func == FN_ALLOC || func == FN_RELEASE || func == FN_SCAN), busy)
endmodule

bind tile_slot_allocator tsa_checker u_tsa_checker (.*);

>>> tb/testbench.sv
`timescale 1ns / 100ps

// Block-level test for tile_slot_allocator.
// Commands go in over start/busy; results come back as done strobes that the
// bench must catch on every cycle. A scoreboard object keeps its own free
// stack and slot table, turns each accepted command into the list of results
// it should cause, and checks every strobe against the oldest one waiting.
module testbench;
	import tsa_pkg::*;

	// func value the block ignores: no result, no state change
	localparam logic [1:0] FN_NONE = 2'd3;

	localparam int RAND_CMDS   = 280;   // random commands that do something
	localparam int STALL_LIMIT = 2000;  // cycles with no transfer at all
	localparam int SETTLE      = 8;     // quiet cycles after the last result

	typedef struct packed {
		logic [1:0]        fn;
		logic [HEAP_W-1:0] heap;
		logic [TEX_W-1:0]  tx;
		logic [TEX_W-1:0]  ty;
		logic [SLOT_W-1:0] s;
	} cmd_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [SLOT_W-1:0] slot;
		logic [HEAP_W-1:0] heap;
		logic [TEX_W-1:0]  tx;
		logic [TEX_W-1:0]  ty;
		logic [CNTP_W-1:0] free_cnt;
		logic              last;
	} tile_result_t;

	// stimulus mix for one stretch of the random part
	typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIX} mix_t;

	// Slot allocator model plus the queue of results it still owes.
	class tile_map_board;
		logic [SLOT_W-1:0] free_stack[SLOTS];
		int                free_top;
		logic [HEAP_W-1:0] map_heap[SLOTS];
		logic [TEX_W-1:0]  map_tx[SLOTS];
		logic [TEX_W-1:0]  map_ty[SLOTS];
		bit                map_used[SLOTS];
		tile_result_t      owed_q[$];

		int mismatches, results_seen;
		int n_alloc, n_release, n_scan, n_ignored;
		int n_full, n_unused, n_empty, max_scan_len;

		function void clear();
			for (int i = 0; i < SLOTS; i++) begin
				free_stack[i] = SLOT_W'(i);
				map_heap[i]   = '0;
				map_tx[i]     = '0;
				map_ty[i]     = '0;
				map_used[i]   = 1'b0;
			end
			free_top = SLOTS;
			owed_q.delete();
		endfunction

		function int free_slots();
			return free_top;
		endfunction

		function int pending();
			return owed_q.size();
		endfunction

		// random slot that currently holds a mapping, -1 if none
		function int pick_used_slot();
			int k;
			if (free_top == SLOTS)
				return -1;
			k = $urandom_range(0, SLOTS - free_top - 1);
			for (int i = 0; i < SLOTS; i++) begin
				if (map_used[i]) begin
					if (k == 0)
						return i;
					k--;
				end
			end
			return -1;
		endfunction

		// free count is taken after the state update of the step
		function void owe(logic [1:0] st, logic [SLOT_W-1:0] s, logic [HEAP_W-1:0] heap,
				logic [TEX_W-1:0] tx, logic [TEX_W-1:0] ty, logic lst);
			tile_result_t r;
			r.status   = st;
			r.slot     = s;
			r.heap     = heap;
			r.tx       = tx;
			r.ty       = ty;
			r.free_cnt = CNTP_W'(free_top);
			r.last     = lst;
			owed_q = {owed_q, r};
		endfunction

		function void note_cmd(cmd_t c);
			logic [SLOT_W-1:0] idx;
			int hits;
			case (c.fn)
				FN_ALLOC: begin
					n_alloc++;
					if (free_top == 0) begin
						n_full++;
						owe(STS_FULL, '0, '0, '0, '0, 1'b1);
					end else begin
						free_top--;
						idx           = free_stack[free_top];
						map_heap[idx] = c.heap;
						map_tx[idx]   = c.tx;
						map_ty[idx]   = c.ty;
						map_used[idx] = 1'b1;
						owe(STS_OK, idx, c.heap, c.tx, c.ty, 1'b1);
					end
				end
				FN_RELEASE: begin
					n_release++;
					if (int'(c.s) >= SLOTS || !map_used[c.s] || free_top >= SLOTS) begin
						n_unused++;
						owe(STS_UNUSED, c.s, '0, '0, '0, 1'b1);
					end else begin
						free_stack[free_top] = c.s;
						free_top++;
						map_used[c.s] = 1'b0;
						owe(STS_OK, c.s, map_heap[c.s], map_tx[c.s], map_ty[c.s], 1'b1);
					end
				end
				FN_SCAN: begin
					n_scan++;
					hits = 0;
					for (int i = 0; i < SLOTS; i++) begin
						if (map_used[i]) begin
							owe(STS_OK, SLOT_W'(i), map_heap[i], map_tx[i], map_ty[i], 1'b0);
							hits++;
						end
					end
					if (hits == 0) begin
						n_empty++;
						owe(STS_EMPTY, '0, '0, '0, '0, 1'b1);
					end else begin
						owed_q[$].last = 1'b1;
					end
					if (hits > max_scan_len)
						max_scan_len = hits;
				end
				default: n_ignored++;
			endcase
		endfunction

		function string fmt(tile_result_t r);
			return $sformatf("st=%0d slot=%0d heap=%h tx=%h ty=%h free=%0d last=%b",
				r.status, r.slot, r.heap, r.tx, r.ty, r.free_cnt, r.last);
		endfunction

		function void flag(string why, tile_result_t want, tile_result_t got);
			mismatches++;
			if (mismatches <= 10) begin
				$display("%0t: %s", $time, why);
				$display("    expected %s", fmt(want));
				$display("    actual   %s", fmt(got));
			end
		endfunction

		function void check_result(tile_result_t got);
			tile_result_t want;
			results_seen++;
			if (owed_q.size() == 0) begin
				want = '0;
				flag("result with nothing pending", want, got);
				return;
			end
			want = owed_q.pop_front();
			if (got.status !== want.status || got.slot !== want.slot
					|| got.heap !== want.heap || got.tx !== want.tx
					|| got.ty !== want.ty || got.free_cnt !== want.free_cnt
					|| got.last !== want.last)
				flag("result mismatch", want, got);
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	logic [1:0]        func = '0;
	logic [HEAP_W-1:0] heap_tile = '0;
	logic [TEX_W-1:0]  tex_x = '0;
	logic [TEX_W-1:0]  tex_y = '0;
	logic [SLOT_W-1:0] slot = '0;
	logic              done;
	logic [1:0]        status;
	logic [SLOT_W-1:0] slot_out;
	logic [HEAP_W-1:0] heap_tile_out;
	logic [TEX_W-1:0]  tex_x_out;
	logic [TEX_W-1:0]  tex_y_out;
	logic [CNTP_W-1:0] free_count;
	logic              last;

	tile_map_board board = new;
	int            stall_cycles = 0;

	tile_slot_allocator DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.func          (func),
		.heap_tile     (heap_tile),
		.tex_x         (tex_x),
		.tex_y         (tex_y),
		.slot          (slot),
		.done          (done),
		.status        (status),
		.slot_out      (slot_out),
		.heap_tile_out (heap_tile_out),
		.tex_x_out     (tex_x_out),
		.tex_y_out     (tex_y_out),
		.free_count    (free_count),
		.last          (last)
	);

	always #4 clk = ~clk;

	// Result side: done is a one-cycle strobe, so every edge with done high is
	// a transfer. Values read here are the ones held during the ending cycle.
	always @(posedge clk) begin
		if (arst_n && done)
			board.check_result('{status, slot_out, heap_tile_out, tex_x_out, tex_y_out,
				free_count, last});
	end

	// Watchdog: any transfer on either side restarts the count. The longest
	// quiet stretch in a good run is a long sender gap plus an empty scan.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("no transfer for %0d cycles, %0d results still owed",
					STALL_LIMIT, board.pending());
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// Sender gap: mostly back to back or short, now and then a long pause.
	function automatic int draw_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Present one command and hold it until it is taken. start stays high
	// on return unless a gap follows, in which case the task drops it, so a
	// back to back command never sees start lowered and raised in the same step.
	task automatic issue(input cmd_t c, input bit no_gap);
		int gap;
		start     <= 1'b1;
		func      <= c.fn;
		heap_tile <= c.heap;
		tex_x     <= c.tx;
		tex_y     <= c.ty;
		slot      <= c.s;
		do
			@(posedge clk);
		while (busy);
		board.note_cmd(c);
		gap = no_gap ? 0 : draw_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic issue_fields(input logic [1:0] fn, input logic [HEAP_W-1:0] heap,
			input logic [TEX_W-1:0] tx, input logic [TEX_W-1:0] ty,
			input logic [SLOT_W-1:0] s);
		cmd_t c;
		c = '{fn, heap, tx, ty, s};
		issue(c, 1'b0);
	endtask

	// Random command shaped by the current mix. Releases mostly hit mapped
	// slots so the table churns; the rest aim at any slot number.
	function automatic cmd_t make_cmd(mix_t mode);
		cmd_t c;
		int r, pick, p_alloc, p_rel, p_noise, p_scan;
		c.heap = HEAP_W'($urandom_range(0, 65535));
		c.tx   = TEX_W'($urandom_range(0, 255));
		c.ty   = TEX_W'($urandom_range(0, 255));
		c.s    = SLOT_W'($urandom_range(0, 63));
		case (mode)
			MODE_FILL:  begin p_alloc = 80; p_rel = 88; p_noise = 93; p_scan = 97; end
			MODE_DRAIN: begin p_alloc = 6;  p_rel = 81; p_noise = 89; p_scan = 96; end
			default:    begin p_alloc = 42; p_rel = 78; p_noise = 84; p_scan = 96; end
		endcase
		r = $urandom_range(0, 99);
		if (r < p_alloc) begin
			c.fn = FN_ALLOC;
		end else if (r < p_rel) begin
			c.fn = FN_RELEASE;
			pick = board.pick_used_slot();
			if (pick >= 0)
				c.s = SLOT_W'(pick);
		end else if (r < p_noise) begin
			c.fn = FN_RELEASE;
		end else if (r < p_scan) begin
			c.fn = FN_SCAN;
		end else begin
			c.fn = FN_NONE;
		end
		return c;
	endfunction

	initial begin
		cmd_t c;
		mix_t mode;
		int   n_rand, epoch, len, extra, k;
		bit   burst;

		board.clear();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty scan, releases of unmapped slots at both ends,
		// ignored selector with all bits set and clear, field extremes on
		// allocate, reuse of a released slot, double release, scan with a few
		// mappings and again once everything is back on the stack.
		issue_fields(FN_SCAN,    16'h0000, 8'h00, 8'h00, 6'd0);
		issue_fields(FN_RELEASE, 16'h0000, 8'h00, 8'h00, 6'd0);
		issue_fields(FN_RELEASE, 16'hFFFF, 8'hFF, 8'hFF, 6'd63);
		issue_fields(FN_NONE,    16'hFFFF, 8'hFF, 8'hFF, 6'd63);
		issue_fields(FN_ALLOC,   16'h0000, 8'h00, 8'h00, 6'd0);
		issue_fields(FN_ALLOC,   16'hFFFF, 8'hFF, 8'hFF, 6'd63);
		issue_fields(FN_ALLOC,   16'h5A3C, 8'h81, 8'h7E, 6'd21);
		issue_fields(FN_SCAN,    16'h0000, 8'h00, 8'h00, 6'd0);
		issue_fields(FN_RELEASE, 16'h0000, 8'h00, 8'h00, 6'd62);
		issue_fields(FN_RELEASE, 16'h0000, 8'h00, 8'h00, 6'd62);
		issue_fields(FN_ALLOC,   16'hA5C3, 8'h3C, 8'hC3, 6'd42);
		issue_fields(FN_RELEASE, 16'h0000, 8'h00, 8'h00, 6'd63);
		issue_fields(FN_SCAN,    16'h0000, 8'h00, 8'h00, 6'd0);
		issue_fields(FN_RELEASE, 16'h0000, 8'h00, 8'h00, 6'd61);
		issue_fields(FN_RELEASE, 16'h0000, 8'h00, 8'h00, 6'd62);
		issue_fields(FN_SCAN,    16'hFFFF, 8'hFF, 8'hFF, 6'd63);
		issue_fields(FN_NONE,    16'h0000, 8'h00, 8'h00, 6'd0);

		// Random: first fill to the no-free-slot case and past it, then drain
		// to empty, then stretches of mixed, fill and drain traffic. Ignored
		// selectors do not count toward the total.
		n_rand = 0;
		epoch  = 0;
		while (n_rand < RAND_CMDS) begin
			if (epoch == 0)
				mode = MODE_FILL;
			else if (epoch == 1)
				mode = MODE_DRAIN;
			else
				mode = mix_t'($urandom_range(0, 2));
			len   = (epoch < 2) ? 200 : $urandom_range(20, 50);
			burst = ($urandom_range(0, 3) == 0);
			extra = 0;
			for (k = 0; k < len && n_rand < RAND_CMDS; k++) begin
				c = make_cmd(mode);
				issue(c, burst);
				if (c.fn != FN_NONE)
					n_rand++;
				// the two opening stretches run until they hit their end state
				if (epoch == 0 && board.free_slots() == 0)
					extra++;
				if (epoch == 1 && board.free_slots() == SLOTS)
					extra++;
				if (epoch < 2 && extra >= 4)
					break;
			end
			epoch++;
		end
		start <= 1'b0;

		while (board.pending() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);

		$display("commands: %0d allocate, %0d release, %0d scan, %0d ignored; %0d results",
			board.n_alloc, board.n_release, board.n_scan, board.n_ignored,
			board.results_seen);
		$display("no-free-slot %0d, unmapped release %0d, empty scan %0d, longest scan %0d",
			board.n_full, board.n_unused, board.n_empty, board.max_scan_len);
		if (board.mismatches == 0 && board.pending() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("%0d mismatches, %0d results never seen", board.mismatches,
				board.pending());
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule

>>> tile_slot_allocator.f
+incdir+src
src/tsa_pkg.sv
src/tsa_free_stack.sv
src/tsa_slot_table.sv
src/tile_slot_allocator.sv
src/tsa_checker.sv
tb/testbench.sv
